FILE: rtl/ueod_pkg.sv
// ----------------------------------------------------------------------------
// ueod_pkg
// Shared widths, register indexes, reset values and bundle types for the
// ultrasonic echo obstacle detector.
// ----------------------------------------------------------------------------
package ueod_pkg;

  // Field and register widths
  localparam int unsigned TimeWidth      = 32;
  localparam int unsigned IntervalWidth  = 16;
  localparam int unsigned ThresholdWidth = 16;
  localparam int unsigned TimeoutWidth   = 8;
  localparam int unsigned CfgDataWidth   = 16;
  localparam int unsigned CfgIndexWidth  = 2;

  // Register indexes on the configuration port
  localparam logic [CfgIndexWidth-1:0] RegIntervalMs    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegThresholdCm   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegEchoTimeoutMs = 2'd2;

  // Register reset values
  localparam logic [IntervalWidth-1:0]  IntervalReset  = 16'd100;
  localparam logic [ThresholdWidth-1:0] ThresholdReset = 16'd0;
  localparam logic [TimeoutWidth-1:0]   TimeoutReset   = 8'd30;

  // Configuration bundle from the register file to the controller
  typedef struct packed {
    logic [IntervalWidth-1:0]  interval_ms;
    logic [ThresholdWidth-1:0] threshold_cm;
    logic [TimeoutWidth-1:0]   echo_timeout_ms;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic detected;
    logic trigger_fire;
    logic measure_done;
    logic timed_out;
  } result_t;

endpackage

FILE: rtl/ueod_cfg_regs.sv
// ----------------------------------------------------------------------------
// ueod_cfg_regs
// Configuration register file: interval, distance threshold and echo timeout.
// ----------------------------------------------------------------------------
module ueod_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ueod_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [ueod_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output ueod_pkg::cfg_t                       cfg_o
);

  ueod_pkg::cfg_t cfg_q;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_ms     <= ueod_pkg::IntervalReset;
      cfg_q.threshold_cm    <= ueod_pkg::ThresholdReset;
      cfg_q.echo_timeout_ms <= ueod_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ueod_pkg::RegIntervalMs: begin
          cfg_q.interval_ms <= cfg_data_i[ueod_pkg::IntervalWidth-1:0];
        end
        ueod_pkg::RegThresholdCm: begin
          cfg_q.threshold_cm <= cfg_data_i[ueod_pkg::ThresholdWidth-1:0];
        end
        ueod_pkg::RegEchoTimeoutMs: begin
          cfg_q.echo_timeout_ms <= cfg_data_i[ueod_pkg::TimeoutWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/ueod_ctrl.sv
// ----------------------------------------------------------------------------
// ueod_ctrl
// Measurement sequencer: phase state, time stamps and cached obstacle flag.
// Computes the result of the presented poll and updates state on step_i.
// ----------------------------------------------------------------------------
module ueod_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [ueod_pkg::TimeWidth-1:0]     now_ms_i,
  input  logic                               echo_level_i,
  input  ueod_pkg::cfg_t                     cfg_i,
  output ueod_pkg::result_t                  res_o
);

  localparam int unsigned TW = ueod_pkg::TimeWidth;
  // Durations that can pass the threshold fit in 12 bits (65535*58/1000 < 4096)
  localparam int unsigned DurCmpWidth = 12;
  localparam int unsigned LimitWidth  = 22;
  localparam logic [LimitWidth-1:0] CmDivisor = 22'd58;
  localparam logic [LimitWidth-1:0] MsToUs    = 22'd1000;

  typedef enum logic [1:0] {
    PhReady     = 2'd0,
    PhWaitStart = 2'd1,
    PhMeasure   = 2'd2
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [TW-1:0]   start_q, start_d;
  logic [TW-1:0]   last_q, last_d;
  logic            detect_q, detect_d;

  logic [TW-1:0]         since_start;
  logic [TW-1:0]         since_last;
  logic                  start_late;
  logic                  interval_over;
  logic [LimitWidth-1:0] limit;
  logic [LimitWidth-1:0] scaled_dur;
  logic                  in_range;
  logic                  fire, done, tout;

  // Elapsed times, modulo the time width
  assign since_start   = now_ms_i - start_q;
  assign since_last    = now_ms_i - last_q;
  assign start_late    = since_start > TW'(cfg_i.echo_timeout_ms);
  assign interval_over = since_last >= TW'(cfg_i.interval_ms);

  // Distance check: dur*1000 <= threshold*58, dur nonzero
  assign limit      = LimitWidth'(cfg_i.threshold_cm) * CmDivisor;
  assign scaled_dur = LimitWidth'(since_start[DurCmpWidth-1:0]) * MsToUs;
  assign in_range   = (since_start != '0)
                   && (since_start[TW-1:DurCmpWidth] == '0)
                   && (scaled_dur <= limit);

  // Next state and result flags
  always_comb begin
    phase_d  = phase_q;
    start_d  = start_q;
    last_d   = last_q;
    detect_d = detect_q;
    fire     = 1'b0;
    done     = 1'b0;
    tout     = 1'b0;
    unique case (phase_q)
      PhWaitStart: begin
        if (echo_level_i) begin
          phase_d = PhMeasure;
          start_d = now_ms_i;
        end else if (start_late) begin
          detect_d = 1'b0;
          phase_d  = PhReady;
          last_d   = now_ms_i;
          done     = 1'b1;
          tout     = 1'b1;
        end
      end
      PhMeasure: begin
        if (!echo_level_i) begin
          detect_d = in_range;
          phase_d  = PhReady;
          last_d   = now_ms_i;
          done     = 1'b1;
        end else if (start_late) begin
          detect_d = 1'b0;
          phase_d  = PhReady;
          last_d   = now_ms_i;
          done     = 1'b1;
          tout     = 1'b1;
        end
      end
      default: begin
        phase_d = PhReady;
        if (interval_over) begin
          phase_d = PhWaitStart;
          start_d = now_ms_i;
          fire    = 1'b1;
        end
      end
    endcase
  end

  assign res_o.detected     = detect_d;
  assign res_o.trigger_fire = fire;
  assign res_o.measure_done = done;
  assign res_o.timed_out    = tout;

  // Hold state; advance on each processed poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhReady;
      start_q  <= '0;
      last_q   <= '0;
      detect_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      start_q  <= start_d;
      last_q   <= last_d;
      detect_q <= detect_d;
    end
  end

endmodule

FILE: rtl/ultrasonic_echo_obstacle_detector_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_obstacle_detector_core
// Polled ultrasonic ranging controller: fires trigger strobes, times the echo
// and keeps a cached obstacle flag against a distance threshold.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  now_ms_i, echo_level_i
//   out      source     out_valid_o / out_stall_i detected_o, trigger_fire_o,
//                                                measure_done_o, timed_out_o
//   cfg      sink       cfg_we_i                cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output does not stall; an item passes
// the input register, then the sequencer logic into the result register.
// Each poll updates the sequencer state in the cycle it moves from the input
// register to the result register, so consecutive polls see each other's state.
// Reset clears both stage valids, the sequencer and the registers to defaults.
// A stall on the output holds the result register and the input register;
// the input stalls only while it holds an item that cannot move on.
// ----------------------------------------------------------------------------
module ultrasonic_echo_obstacle_detector_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ueod_pkg::TimeWidth-1:0]     now_ms_i,
  input  logic                               echo_level_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               detected_o,
  output logic                               trigger_fire_o,
  output logic                               measure_done_o,
  output logic                               timed_out_o,
  input  logic                               cfg_we_i,
  input  logic [ueod_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [ueod_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  ueod_pkg::cfg_t    cfg;
  ueod_pkg::result_t res;
  ueod_pkg::result_t res_q;

  logic                           in_valid_q;
  logic [ueod_pkg::TimeWidth-1:0] now_q;
  logic                           echo_q;
  logic                           out_valid_q;
  logic                           in_take;
  logic                           advance;

  // Stage handshakes
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  ueod_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ueod_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .now_ms_i     (now_q),
    .echo_level_i (echo_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q  <= now_ms_i;
      echo_q <= echo_level_i;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign detected_o     = res_q.detected;
  assign trigger_fire_o = res_q.trigger_fire;
  assign measure_done_o = res_q.measure_done;
  assign timed_out_o    = res_q.timed_out;

`ifndef SYNTHESIS
  // A timeout always ends a measurement
  a_tout_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!timed_out_o || measure_done_o))
    else $error("timed_out without measure_done");

  // A poll never both starts and ends a measurement
  a_fire_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(trigger_fire_o && measure_done_o))
    else $error("trigger_fire together with measure_done");

  // Never overwrite a result that is waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !advance)
    else $error("result register overwritten while stalled");

  // Input stalls only while holding an item
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled while empty");

  // A processed item always appears at the output next cycle
  a_advance_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item lost");
`endif

endmodule

FILE: sim/ultrasonic_echo_obstacle_detector_core_tb.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_obstacle_detector_core_tb
// Drives timed echo polls into the ranging controller and checks every result
// item against a cycle-free model of the trigger/wait/measure sequencer. A
// short directed run covers trigger, zero and late echoes, both timeouts and
// time wrap; random measurement episodes with noise follow under several
// register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module ultrasonic_echo_obstacle_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ueod_pkg::CfgIndexWidth-1:0] RegUnused = 2'd3;
  localparam int unsigned CmPerMs      = 58;
  localparam int unsigned MsToUs       = 1000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned CycleLimit   = 200000;

  typedef enum logic [1:0] {
    PhReady     = 2'd0,
    PhWaitStart = 2'd1,
    PhMeasure   = 2'd2
  } seq_phase_e;

  typedef struct packed {
    logic [ueod_pkg::TimeWidth-1:0] now_ms;
    logic                           echo;
  } poll_t;

  // Clock, reset and block ports
  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [ueod_pkg::TimeWidth-1:0]     now_ms = '0;
  logic                               echo_level = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               detected;
  logic                               trigger_fire;
  logic                               measure_done;
  logic                               timed_out;
  logic                               cfg_we = 1'b0;
  logic [ueod_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [ueod_pkg::CfgDataWidth-1:0]  cfg_data = '0;

  // Sequencer model state and register copies
  seq_phase_e                          seq_phase = PhReady;
  logic [ueod_pkg::TimeWidth-1:0]      seq_start_ms = '0;
  logic [ueod_pkg::TimeWidth-1:0]      last_end_ms = '0;
  logic                                cached_detect = 1'b0;
  logic [ueod_pkg::IntervalWidth-1:0]  cfg_interval = ueod_pkg::IntervalReset;
  logic [ueod_pkg::ThresholdWidth-1:0] cfg_threshold = ueod_pkg::ThresholdReset;
  logic [ueod_pkg::TimeoutWidth-1:0]   cfg_timeout = ueod_pkg::TimeoutReset;

  poll_t                          pending_polls[$];
  ueod_pkg::result_t              expected_results[$];
  poll_t                          next_poll;
  int unsigned                    send_idle_pct = 0;
  int unsigned                    recv_idle_pct = 0;
  int unsigned                    mismatches = 0;
  int unsigned                    gen_count = 0;
  logic [ueod_pkg::TimeWidth-1:0] gen_t = '0;

  ultrasonic_echo_obstacle_detector_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .now_ms_i       (now_ms),
    .echo_level_i   (echo_level),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .detected_o     (detected),
    .trigger_fire_o (trigger_fire),
    .measure_done_o (measure_done),
    .timed_out_o    (timed_out),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Advance the sequencer model by one poll and return the result item
  function automatic ueod_pkg::result_t predict_poll(
      input logic [ueod_pkg::TimeWidth-1:0] now, input logic echo);
    ueod_pkg::result_t              res;
    logic [ueod_pkg::TimeWidth-1:0] span;
    res = '0;
    case (seq_phase)
      PhWaitStart: begin
        span = now - seq_start_ms;
        if (echo) begin
          seq_phase    = PhMeasure;
          seq_start_ms = now;
        end else if (span > cfg_timeout) begin
          cached_detect    = 1'b0;
          seq_phase        = PhReady;
          last_end_ms      = now;
          res.measure_done = 1'b1;
          res.timed_out    = 1'b1;
        end
      end
      PhMeasure: begin
        span = now - seq_start_ms;
        if (!echo) begin
          // distance check in integers: span*1000 <= threshold*58
          cached_detect = (span != '0) &&
              (64'(span) * MsToUs <= 64'(cfg_threshold) * CmPerMs);
          seq_phase        = PhReady;
          last_end_ms      = now;
          res.measure_done = 1'b1;
        end else if (span > cfg_timeout) begin
          cached_detect    = 1'b0;
          seq_phase        = PhReady;
          last_end_ms      = now;
          res.measure_done = 1'b1;
          res.timed_out    = 1'b1;
        end
      end
      default: begin
        seq_phase = PhReady;
        span = now - last_end_ms;
        if (span >= cfg_interval) begin
          seq_phase        = PhWaitStart;
          seq_start_ms     = now;
          res.trigger_fire = 1'b1;
        end
      end
    endcase
    res.detected = cached_detect;
    return res;
  endfunction

  // Driver: present pending polls, hold while stalled, idle at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      now_ms     <= '0;
      echo_level <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_poll(now_ms, echo_level));
      end
      if (!in_valid || !in_stall) begin
        if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_poll  = pending_polls.pop_front();
          in_valid   <= 1'b1;
          now_ms     <= next_poll.now_ms;
          echo_level <= next_poll.echo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_result(input string what, input ueod_pkg::result_t want,
                             input ueod_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected det=%0b trig=%0b done=%0b tout=%0b,",
               what, want.detected, want.trigger_fire, want.measure_done,
               want.timed_out);
      $display("  got det=%0b trig=%0b done=%0b tout=%0b",
               got.detected, got.trigger_fire, got.measure_done, got.timed_out);
    end
  endtask

  // Monitor: stall at random, compare each accepted result with the oldest one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag_result("unexpected result", '0,
                      '{detected, trigger_fire, measure_done, timed_out});
        end else if (expected_results[0].detected !== detected ||
                     expected_results[0].trigger_fire !== trigger_fire ||
                     expected_results[0].measure_done !== measure_done ||
                     expected_results[0].timed_out !== timed_out) begin
          flag_result("result mismatch", expected_results.pop_front(),
                      '{detected, trigger_fire, measure_done, timed_out});
        end else begin
          void'(expected_results.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [ueod_pkg::CfgIndexWidth-1:0] idx,
                           input logic [ueod_pkg::CfgDataWidth-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      ueod_pkg::RegIntervalMs:    cfg_interval = data;
      ueod_pkg::RegThresholdCm:   cfg_threshold = data;
      ueod_pkg::RegEchoTimeoutMs: cfg_timeout = data[ueod_pkg::TimeoutWidth-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input logic [15:0] interval, input logic [15:0] threshold,
                              input logic [7:0] timeout);
    write_reg(ueod_pkg::RegIntervalMs, interval);
    write_reg(ueod_pkg::RegThresholdCm, threshold);
    // upper byte is dropped by the block
    write_reg(ueod_pkg::RegEchoTimeoutMs, {8'($urandom_range(255)), timeout});
  endtask

  task automatic push_poll(input logic [ueod_pkg::TimeWidth-1:0] t, input logic e);
    pending_polls.push_back('{now_ms: t, echo: e});
    gen_count++;
  endtask

  // Hold until every poll is accepted and every result has come back
  task automatic drain();
    while (pending_polls.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One measurement: trigger, wait for the rise, time the high phase
  task automatic gen_episode();
    int unsigned                    lim_ms;
    int unsigned                    dur;
    int unsigned                    cap;
    int unsigned                    n;
    logic [ueod_pkg::TimeWidth-1:0] rise_t;
    lim_ms = 32'(cfg_threshold) * CmPerMs / MsToUs;
    // early poll before the interval has run out
    if (cfg_interval > 1 && $urandom_range(1) == 1)
      push_poll(gen_t + $urandom_range(int'(cfg_interval) - 1), 1'($urandom_range(1)));
    gen_t += cfg_interval + (($urandom_range(2) == 0) ? 0 : $urandom_range(4));
    push_poll(gen_t, 1'b0);
    case ($urandom_range(7))
      0: begin
        // echo never rises
        gen_t += cfg_timeout + 1 + $urandom_range(3);
        push_poll(gen_t, 1'b0);
        return;
      end
      1: begin
        gen_t += cfg_timeout;
        push_poll(gen_t, 1'b0);
      end
      default: begin
        n = $urandom_range(2);
        repeat (n) begin
          gen_t += $urandom_range(1);
          push_poll(gen_t, 1'b0);
        end
        gen_t += $urandom_range(1);
      end
    endcase
    push_poll(gen_t, 1'b1);
    rise_t = gen_t;
    case ($urandom_range(5))
      0: dur = 0;
      1: dur = lim_ms;
      2: dur = lim_ms + 1;
      3: dur = $urandom_range(cfg_timeout);
      4: dur = cfg_timeout + 1 + $urandom_range(60);
      default: begin
        // echo still high past the timeout
        push_poll(rise_t + cfg_timeout + 1 + $urandom_range(3), 1'b1);
        gen_t = rise_t + cfg_timeout + 4;
        return;
      end
    endcase
    cap = (dur < cfg_timeout) ? dur : 32'(cfg_timeout);
    n = $urandom_range(3);
    repeat (n) push_poll(rise_t + $urandom_range(cap), 1'b1);
    gen_t = rise_t + dur;
    push_poll(gen_t, 1'b0);
  endtask

  task automatic fill_polls(input int unsigned target);
    while (gen_count < target) begin
      if ($urandom_range(5) == 0) begin
        // noise: random times and levels
        repeat ($urandom_range(3, 1)) push_poll($urandom, 1'($urandom_range(1)));
        gen_t = pending_polls[$].now_ms;
      end else begin
        gen_episode();
      end
    end
  endtask

  // Random phase in two halves with a full drain in between
  task automatic run_phase(input int unsigned n_items, input int unsigned send_pct,
                           input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if ($urandom_range(1) == 1) gen_t = 32'hFFFF_FFFF - $urandom_range(400);
    gen_count = 0;
    fill_polls(n_items / 2);
    drain();
    fill_polls(n_items);
    drain();
  endtask

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 77;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_config(16'd5, 16'd100, 8'd10);
    write_reg(RegUnused, 16'($urandom));

    // no trigger before the interval, then trigger
    push_poll(32'd0, 1'b0);
    push_poll(32'd5, 1'b0);
    // echo rises and falls within one ms
    push_poll(32'd6, 1'b1);
    push_poll(32'd6, 1'b0);
    // echo inside the threshold
    push_poll(32'd11, 1'b0);
    push_poll(32'd12, 1'b1);
    push_poll(32'd17, 1'b0);
    // echo never rises
    push_poll(32'd22, 1'b0);
    push_poll(32'd33, 1'b0);
    // rise exactly at the timeout, echo just beyond the threshold
    push_poll(32'd38, 1'b0);
    push_poll(32'd48, 1'b0);
    push_poll(32'd48, 1'b1);
    push_poll(32'd54, 1'b0);
    // echo stays high too long
    push_poll(32'd59, 1'b0);
    push_poll(32'd59, 1'b1);
    push_poll(32'd70, 1'b1);
    // falling edge seen late
    push_poll(32'd75, 1'b0);
    push_poll(32'd75, 1'b1);
    push_poll(32'd200, 1'b0);
    // time wraps during the echo
    push_poll(32'hFFFF_FFFE, 1'b0);
    push_poll(32'hFFFF_FFFF, 1'b1);
    push_poll(32'd3, 1'b0);
    push_poll(32'd0, 1'b0);
    drain();

    apply_config(16'd0, 16'hFFFF, 8'd255);
    run_phase(130, 7, 77);

    apply_config(16'hFFFF, 16'd0, 8'd0);
    run_phase(130, 77, 7);

    apply_config(16'($urandom_range(200, 1)), 16'($urandom_range(2000, 1)),
                 8'($urandom_range(60, 1)));
    run_phase(70, 0, 0);

    apply_config(16'd100, 16'd300, 8'd30);
    run_phase(70, 0, 0);

    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
